[rtl/core/stq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Sizes, operation and status codes, and the saturating expiry add.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = $clog2(TIMER_SLOTS);
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
    localparam int RIX_W       = $clog2(MAX_RESULTS);
    localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W      = 48;
    localparam int ID_W        = 32;

    typedef logic [1:0]        op_t;
    typedef logic [1:0]        status_t;
    typedef logic [TIME_W-1:0] time_t;
    typedef logic [ID_W-1:0]   ident_t;

    localparam op_t OP_ARM_ONCE   = 2'd0;
    localparam op_t OP_ARM_REPEAT = 2'd1;
    localparam op_t OP_CANCEL     = 2'd2;
    localparam op_t OP_TICK       = 2'd3;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_NOT_FOUND = 2'd2;

    function automatic time_t sat_add(input time_t now, input ident_t delay);
        logic [TIME_W:0] sum;
        begin
            sum = {1'b0, now} + {{(TIME_W + 1 - ID_W){1'b0}}, delay};
            sat_add = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/sorted_timer_queue_unit.sv]
// ----------------------------------------------------------------------------
// Sorted timer queue
// Timer table kept sorted by expiry, with arm, cancel and tick operations.
// ----------------------------------------------------------------------------
// Arm: a new id is issued, the slots are scanned for the insert point and the
// timer is inserted, then 1 result. Cancel: the slots are scanned for the id
// and the match is removed, then 1 result. Tick: the due slots are scanned, each
// fired timer is popped, and each repeating timer is scanned for and reinserted;
// results follow at one per cycle while m_ready is high. Slot scanning is the limiting resource.
// Reset clears the timer count, the id counter and control; slots are unset.
`default_nettype none

module sorted_timer_queue_unit
    import stq_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [1:0]   s_op,
    input  wire logic [47:0]  s_now_ms,
    input  wire logic [31:0]  s_delay_ms,
    input  wire logic [31:0]  s_cancel_id,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [31:0]       m_timer_id,
    output logic [1:0]        m_status,
    output logic              m_fired,
    output logic              m_last,
    output logic              m_idle
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIND   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_CSCAN  = 3'd3;
    localparam logic [2:0] S_REMOVE = 3'd4;
    localparam logic [2:0] S_DUE    = 3'd5;
    localparam logic [2:0] S_TPOP   = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [2:0]        state_reg;
    logic [CNT_W-1:0]  count_reg;
    ident_t            next_id_reg;
    logic [CNT_W-1:0]  pos_reg;
    op_t               op_reg;
    time_t             now_reg;
    ident_t            cid_reg;
    time_t             ins_exp_reg;
    ident_t            ins_per_reg;
    ident_t            ins_id_reg;
    logic              ins_rep_reg;
    logic [RCNT_W-1:0] due_reg;
    logic [RCNT_W-1:0] pop_reg;
    logic [RCNT_W-1:0] res_n_reg;
    logic [RIX_W-1:0]  emit_reg;
    status_t           status_reg;
    logic              fired_reg;

    time_t  slot_exp   [TIMER_SLOTS];
    ident_t slot_per   [TIMER_SLOTS];
    ident_t slot_id    [TIMER_SLOTS];
    logic   slot_rep   [TIMER_SLOTS];
    ident_t res_buf    [MAX_RESULTS];

    logic             do_ins;
    logic             do_rm;
    logic [IDX_W-1:0] sh_pos;
    logic [IDX_W-1:0] rd_pos;
    logic             pos_valid;
    logic [RCNT_W-1:0] emit_ext;

    assign rd_pos    = pos_reg[IDX_W-1:0];
    assign pos_valid = pos_reg < count_reg;
    assign emit_ext  = RCNT_W'(emit_reg);

    always_comb begin
        do_ins = (state_reg == S_SHIFT);
        do_rm  = (state_reg == S_REMOVE) || (state_reg == S_TPOP);
        sh_pos = (state_reg == S_TPOP) ? '0 : rd_pos;
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (do_rm && i >= int'(sh_pos) && i < TIMER_SLOTS - 1) begin
                slot_exp[i] <= slot_exp[i+1];
                slot_per[i] <= slot_per[i+1];
                slot_id[i]  <= slot_id[i+1];
                slot_rep[i] <= slot_rep[i+1];
            end else if (do_ins && i > int'(sh_pos)) begin
                slot_exp[i] <= slot_exp[i-1];
                slot_per[i] <= slot_per[i-1];
                slot_id[i]  <= slot_id[i-1];
                slot_rep[i] <= slot_rep[i-1];
            end else if (do_ins && i == int'(sh_pos)) begin
                slot_exp[i] <= ins_exp_reg;
                slot_per[i] <= ins_per_reg;
                slot_id[i]  <= ins_id_reg;
                slot_rep[i] <= ins_rep_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            next_id_reg <= '0;
            emit_reg    <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg   <= s_op;
                        now_reg  <= s_now_ms;
                        cid_reg  <= s_cancel_id;
                        pos_reg  <= '0;
                        emit_reg <= '0;
                        res_n_reg <= RCNT_W'(1);
                        fired_reg <= 1'b0;
                        status_reg <= ST_OK;
                        unique case (s_op)
                            OP_ARM_ONCE, OP_ARM_REPEAT: begin
                                if (int'(count_reg) >= TIMER_SLOTS) begin
                                    status_reg <= ST_FULL;
                                    res_buf[0] <= '0;
                                    state_reg  <= S_EMIT;
                                end else begin
                                    next_id_reg <= next_id_reg + 1'b1;
                                    ins_id_reg  <= next_id_reg + 1'b1;
                                    res_buf[0]  <= next_id_reg + 1'b1;
                                    ins_exp_reg <= sat_add(s_now_ms, s_delay_ms);
                                    ins_per_reg <= s_delay_ms;
                                    ins_rep_reg <= (s_op == OP_ARM_REPEAT);
                                    state_reg   <= S_FIND;
                                end
                            end
                            OP_CANCEL: begin
                                res_buf[0] <= '0;
                                state_reg  <= S_CSCAN;
                            end
                            OP_TICK: begin
                                state_reg <= S_DUE;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_FIND: begin
                    if (pos_valid && slot_exp[rd_pos] <= ins_exp_reg) begin
                        pos_reg <= pos_reg + 1'b1;
                    end else begin
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    count_reg <= count_reg + 1'b1;
                    if (op_reg == OP_TICK && pop_reg != due_reg) begin
                        state_reg <= S_TPOP;
                    end else begin
                        state_reg <= S_EMIT;
                    end
                end
                S_CSCAN: begin
                    if (!pos_valid) begin
                        status_reg <= ST_NOT_FOUND;
                        state_reg  <= S_EMIT;
                    end else if (slot_id[rd_pos] == cid_reg) begin
                        state_reg <= S_REMOVE;
                    end else begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                S_REMOVE: begin
                    count_reg <= count_reg - 1'b1;
                    state_reg <= S_EMIT;
                end
                S_DUE: begin
                    if (pos_valid && int'(pos_reg) < MAX_RESULTS
                            && slot_exp[rd_pos] <= now_reg) begin
                        pos_reg <= pos_reg + 1'b1;
                    end else if (pos_reg == '0) begin
                        res_buf[0] <= '0;
                        state_reg  <= S_EMIT;
                    end else begin
                        due_reg   <= RCNT_W'(pos_reg);
                        res_n_reg <= RCNT_W'(pos_reg);
                        pop_reg   <= '0;
                        fired_reg <= 1'b1;
                        state_reg <= S_TPOP;
                    end
                end
                S_TPOP: begin
                    res_buf[pop_reg[RIX_W-1:0]] <= slot_id[0];
                    ins_id_reg  <= slot_id[0];
                    ins_per_reg <= slot_per[0];
                    ins_rep_reg <= 1'b1;
                    ins_exp_reg <= sat_add(now_reg, slot_per[0]);
                    count_reg   <= count_reg - 1'b1;
                    pop_reg     <= pop_reg + 1'b1;
                    pos_reg     <= '0;
                    if (slot_rep[0]) begin
                        state_reg <= S_FIND;
                    end else if (pop_reg + 1'b1 == due_reg) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (m_ready) begin
                        if (emit_ext + 1'b1 == res_n_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            emit_reg <= emit_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = (state_reg == S_EMIT);
    assign m_timer_id = res_buf[emit_reg];
    assign m_status   = status_reg;
    assign m_fired    = fired_reg;
    assign m_last     = (emit_ext + 1'b1 == res_n_reg);
    assign m_idle     = (count_reg == '0);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= TIMER_SLOTS)
        else $error("timer count exceeds table size");

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result sides active together");

    a_fired_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fired |-> m_status == ST_OK)
        else $error("fired result with nonzero status");

    a_emit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> emit_ext < res_n_reg)
        else $error("result index past result count");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && $past(m_valid) |-> $stable(count_reg))
        else $error("timer count changed while results drain");

endmodule

`default_nettype wire
